### sv/bdd_pkg.sv
// Shared types and constants for the Bayer 2x2 downsample demosaic block.
package bdd_pkg;

	typedef enum logic [1:0] {
		TILE_RGGB = 2'd0,
		TILE_GBRG = 2'd1,
		TILE_GRBG = 2'd2,
		TILE_BGGR = 2'd3
	} bdd_tile_t;

	typedef enum logic [0:0] {
		REG_TILE_PATTERN = 1'b0,
		REG_LINE_WIDTH   = 1'b1
	} bdd_reg_t;

	localparam int unsigned CFG_DATA_W = 12;
	localparam logic [CFG_DATA_W-1:0] LINE_WIDTH_RESET = 12'd640;

	typedef struct packed {
		logic [7:0] pixel;
		logic       frame_start;
	} bdd_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       row_end;
	} bdd_out_t;

	typedef struct packed {
		logic [7:0] tl;
		logic [7:0] tr;
		logic [7:0] bl;
		logic [7:0] br;
		logic       row_end;
	} bdd_quad_t;

endpackage

### sv/bayer_downsample_demosaic_core.sv
// Top level of the Bayer 2x2 downsample demosaic block.
//
// channel   direction  handshake                     payload
// sample    in         sample_valid / sample_ready   bdd_in_t  (pixel, frame_start)
// rgb       out        rgb_valid / rgb_ready         bdd_out_t (red, green, blue, row_end)
// cfg       in         cfg_we                        cfg_index, cfg_data
//
// One sample beat per cycle while sample_ready is high.
// Latency is set by the registered line store read plus the output register.
// Reset clears position, config and pipeline valids; the line store is not cleared.
// With rgb stalled, sample_ready drops only once both the read stage and output are full.
module bayer_downsample_demosaic_core #(
	parameter int unsigned MAX_LINE_WIDTH = 2048
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_ready,
	input  bdd_pkg::bdd_in_t                   sample,
	output logic                               rgb_valid,
	input  logic                               rgb_ready,
	output bdd_pkg::bdd_out_t                  rgb,
	input  logic                               cfg_we,
	input  bdd_pkg::bdd_reg_t                  cfg_index,
	input  logic [bdd_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bdd_pkg::*;

	localparam int unsigned CW    = $clog2(MAX_LINE_WIDTH + 1);
	localparam int unsigned DEPTH = (MAX_LINE_WIDTH + 1) / 2;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned EW    = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
	localparam logic [EW-1:0] MAX_W = EW'(MAX_LINE_WIDTH);
	localparam logic [EW-1:0] MIN_W = EW'(2);

	bdd_tile_t             tile_q;
	logic [CFG_DATA_W-1:0] line_width_q;
	logic [CW-1:0]         col_q;
	logic                  odd_q;
	logic [7:0]            held_q;

	logic                  s1_valid_s1;
	logic [7:0]            br_s1;
	logic [7:0]            bl_s1;
	logic                  row_end_s1;

	logic                  out_valid_q;
	bdd_out_t              out_q;

	logic [EW-1:0]         lw_ext;
	logic [CW-1:0]         eff_w;
	logic [CW-1:0]         last_col;
	logic [CW-1:0]         col_start;
	logic                  odd_start;
	logic [CW-1:0]         col;
	logic                  odd;
	logic [CW-1:0]         col_inc;
	logic                  accept;
	logic                  produce;
	logic                  advance;
	logic [7:0]            tl_rd;
	logic [7:0]            tr_rd;
	bdd_quad_t             quad;
	bdd_out_t              quad_rgb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_q       <= TILE_RGGB;
			line_width_q <= LINE_WIDTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TILE_PATTERN: tile_q       <= bdd_tile_t'(cfg_data[1:0]);
				REG_LINE_WIDTH:   line_width_q <= cfg_data;
				default:          tile_q       <= tile_q;
			endcase
		end
	end

	always_comb begin
		lw_ext = EW'(line_width_q);
		if (lw_ext < MIN_W) begin
			eff_w = CW'(MIN_W);
		end else if (lw_ext > MAX_W) begin
			eff_w = CW'(MAX_W);
		end else begin
			eff_w = CW'(lw_ext);
		end
		last_col = {eff_w[CW-1:1], 1'b0} - CW'(1);
	end

	always_comb begin
		col_start = sample.frame_start ? '0 : col_q;
		odd_start = sample.frame_start ? 1'b0 : odd_q;
		if (col_start >= eff_w) begin
			col = '0;
			odd = ~odd_start;
		end else begin
			col = col_start;
			odd = odd_start;
		end
		col_inc = col + CW'(1);
	end

	assign advance      = !out_valid_q || rgb_ready;
	assign sample_ready = !s1_valid_s1 || advance;
	assign accept       = sample_valid && sample_ready;
	assign produce      = odd && col[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			odd_q  <= 1'b0;
			held_q <= '0;
		end else if (accept) begin
			if (col_inc >= eff_w) begin
				col_q <= '0;
				odd_q <= ~odd;
			end else begin
				col_q <= col_inc;
				odd_q <= odd;
			end
			if (odd && !col[0]) begin
				held_q <= sample.pixel;
			end
		end
	end

	bdd_line_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk       (clk),
		.wr_en     (accept && !odd),
		.wr_bank   (col[0]),
		.addr      (col[AW:1]),
		.wr_data   (sample.pixel),
		.rd_en     (accept && produce),
		.even_data (tl_rd),
		.odd_data  (tr_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept && produce) begin
			s1_valid_s1 <= 1'b1;
		end else if (advance) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && produce) begin
			br_s1      <= sample.pixel;
			bl_s1      <= held_q;
			row_end_s1 <= (col == last_col);
		end
	end

	always_comb begin
		quad.tl      = tl_rd;
		quad.tr      = tr_rd;
		quad.bl      = bl_s1;
		quad.br      = br_s1;
		quad.row_end = row_end_s1;
	end

	bdd_quad u_quad (
		.tile (tile_q),
		.quad (quad),
		.rgb  (quad_rgb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid_s1) begin
			out_q <= quad_rgb;
		end
	end

	assign rgb_valid = out_valid_q;
	assign rgb       = out_q;

endmodule

### sv/bdd_line_store.sv
// Even-row line store: even and odd columns in two banks, registered read.
module bdd_line_store #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic          wr_bank,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	output logic [7:0]    even_data,
	output logic [7:0]    odd_data
);

	logic [7:0] even_mem [DEPTH];
	logic [7:0] odd_mem  [DEPTH];
	logic [7:0] even_rd_q;
	logic [7:0] odd_rd_q;

	always_ff @(posedge clk) begin
		if (wr_en && !wr_bank) begin
			even_mem[addr] <= wr_data;
		end
		if (rd_en) begin
			even_rd_q <= even_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_bank) begin
			odd_mem[addr] <= wr_data;
		end
		if (rd_en) begin
			odd_rd_q <= odd_mem[addr];
		end
	end

	assign even_data = even_rd_q;
	assign odd_data  = odd_rd_q;

endmodule

### sv/bdd_quad.sv
// Color selection and green averaging for one 2x2 quad.
module bdd_quad (
	input  bdd_pkg::bdd_tile_t tile,
	input  bdd_pkg::bdd_quad_t quad,
	output bdd_pkg::bdd_out_t  rgb
);
	import bdd_pkg::*;

	logic [8:0] diag_sum;
	logic [8:0] anti_sum;

	assign diag_sum = {1'b0, quad.tl} + {1'b0, quad.br};
	assign anti_sum = {1'b0, quad.tr} + {1'b0, quad.bl};

	always_comb begin
		rgb.row_end = quad.row_end;
		unique case (tile)
			TILE_RGGB: begin
				rgb.red   = quad.tl;
				rgb.blue  = quad.br;
				rgb.green = anti_sum[8:1];
			end
			TILE_GBRG: begin
				rgb.red   = quad.bl;
				rgb.blue  = quad.tr;
				rgb.green = diag_sum[8:1];
			end
			TILE_GRBG: begin
				rgb.red   = quad.tr;
				rgb.blue  = quad.bl;
				rgb.green = diag_sum[8:1];
			end
			TILE_BGGR: begin
				rgb.red   = quad.br;
				rgb.blue  = quad.tl;
				rgb.green = anti_sum[8:1];
			end
			default: begin
				rgb.red   = quad.tl;
				rgb.blue  = quad.br;
				rgb.green = anti_sum[8:1];
			end
		endcase
	end

endmodule

### sv/bdd_checker.sv
// Port-level checker for the demosaic core, bound to the top level.
module bdd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_ready,
	input bdd_pkg::bdd_in_t  sample,
	input logic              rgb_valid,
	input logic              rgb_ready,
	input bdd_pkg::bdd_out_t rgb
);
	import bdd_pkg::*;

	a_rgb_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && !rgb_ready |=> rgb_valid && $stable(rgb))
		else $error("rgb beat dropped or changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> rgb_valid && !rgb_ready)
		else $error("sample_ready low without output backpressure");

	a_rgb_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rgb_valid) |-> $past(sample_valid && sample_ready, 2))
		else $error("rgb beat without a preceding sample beat");

	a_frame_start_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready && sample.frame_start |=> ##1 !$rose(rgb_valid))
		else $error("rgb beat caused by a frame start sample");

endmodule

bind bayer_downsample_demosaic_core bdd_checker u_bdd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.sample       (sample),
	.rgb_valid    (rgb_valid),
	.rgb_ready    (rgb_ready),
	.rgb          (rgb)
);

### tb/bdd_rgb_checker.sv
// Scoreboard for the demosaic core: predicts rgb beats from sample beats and register writes.
module bdd_rgb_checker #(
	parameter int unsigned MAX_LINE_WIDTH = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	input  logic                           sample_ready,
	input  bdd_pkg::bdd_in_t               sample,
	input  logic                           rgb_valid,
	input  logic                           rgb_ready,
	input  bdd_pkg::bdd_out_t              rgb,
	input  logic                           cfg_we,
	input  bdd_pkg::bdd_reg_t              cfg_index,
	input  logic [bdd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int unsigned                    mismatches,
	output int unsigned                    outstanding,
	output int unsigned                    rgb_checked
);
	import bdd_pkg::*;

	logic [7:0]            line_store [MAX_LINE_WIDTH];
	bdd_out_t              rgb_expected [$];
	bdd_out_t              oldest;
	bdd_tile_t             tile;
	logic [CFG_DATA_W-1:0] width_reg;
	int unsigned           col_pos;
	logic                  odd_row;
	logic [7:0]            held_left;

	function automatic int unsigned active_width();
		if (width_reg < 2) return 2;
		if (width_reg > MAX_LINE_WIDTH) return MAX_LINE_WIDTH;
		return 32'(width_reg);
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("rgb mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic take_sample(input bdd_in_t s);
		int unsigned w;
		logic [7:0] tl, tr, bl, br;
		logic [8:0] g_sum;
		bdd_out_t   px_out;
		w = active_width();
		if (s.frame_start) begin
			col_pos = 0;
			odd_row = 1'b0;
		end
		if (col_pos >= w) begin
			col_pos = 0;
			odd_row = ~odd_row;
		end
		if (!odd_row) begin
			line_store[col_pos] = s.pixel;
		end else if (col_pos[0]) begin
			tl = line_store[col_pos - 1];
			tr = line_store[col_pos];
			bl = held_left;
			br = s.pixel;
			case (tile)
				TILE_RGGB: begin
					px_out.red  = tl;
					px_out.blue = br;
					g_sum       = {1'b0, tr} + {1'b0, bl};
				end
				TILE_GBRG: begin
					px_out.red  = bl;
					px_out.blue = tr;
					g_sum       = {1'b0, tl} + {1'b0, br};
				end
				TILE_GRBG: begin
					px_out.red  = tr;
					px_out.blue = bl;
					g_sum       = {1'b0, tl} + {1'b0, br};
				end
				default: begin
					px_out.red  = br;
					px_out.blue = tl;
					g_sum       = {1'b0, tr} + {1'b0, bl};
				end
			endcase
			px_out.green   = g_sum[8:1];
			px_out.row_end = (col_pos == (w & ~32'd1) - 32'd1);
			rgb_expected.insert(rgb_expected.size(), px_out);
		end else begin
			held_left = s.pixel;
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			odd_row = ~odd_row;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb_expected.delete();
			tile        = TILE_RGGB;
			width_reg   = LINE_WIDTH_RESET;
			col_pos     = 0;
			odd_row     = 1'b0;
			held_left   = 8'd0;
			mismatches  = 0;
			outstanding = 0;
			rgb_checked = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_TILE_PATTERN) tile = bdd_tile_t'(cfg_data[1:0]);
				else width_reg = cfg_data;
			end
			if (rgb_valid && rgb_ready) begin
				if (rgb_expected.size() == 0) begin
					flag_mismatch("rgb beat with nothing expected");
				end else begin
					oldest = rgb_expected.pop_front();
					if (rgb.red !== oldest.red)
						flag_mismatch($sformatf("red %0d, expected %0d", rgb.red, oldest.red));
					if (rgb.green !== oldest.green)
						flag_mismatch($sformatf("green %0d, expected %0d", rgb.green,
							oldest.green));
					if (rgb.blue !== oldest.blue)
						flag_mismatch($sformatf("blue %0d, expected %0d", rgb.blue, oldest.blue));
					if (rgb.row_end !== oldest.row_end)
						flag_mismatch($sformatf("row_end %0b, expected %0b", rgb.row_end,
							oldest.row_end));
					rgb_checked++;
				end
			end
			if (sample_valid && sample_ready) take_sample(sample);
			outstanding = rgb_expected.size();
		end
	end

endmodule

### tb/tb_bayer_downsample_demosaic_core.sv
// Testbench top for the demosaic core: sample stimulus, register writes, rgb back-pressure, verdict.
module tb_bayer_downsample_demosaic_core;
	import bdd_pkg::*;

	localparam int unsigned MAX_W       = 2048;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned PHASE_BEATS = 250;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  sample_valid;
	logic                  sample_ready;
	bdd_in_t               sample;
	logic                  rgb_valid;
	logic                  rgb_ready;
	bdd_out_t              rgb;
	logic                  cfg_we;
	bdd_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int unsigned           mismatches;
	int unsigned           outstanding;
	int unsigned           rgb_checked;
	int unsigned           send_idle_pct  = 0;
	int unsigned           recv_stall_pct = 0;
	int unsigned           hold_requests  = 0;
	int unsigned           hold_served    = 0;
	int unsigned           beats_sent     = 0;
	int unsigned           reg_writes     = 0;
	logic [CFG_DATA_W-1:0] width_now;

	always #5 clk = ~clk;

	bayer_downsample_demosaic_core #(
		.MAX_LINE_WIDTH(MAX_W)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample      (sample),
		.rgb_valid   (rgb_valid),
		.rgb_ready   (rgb_ready),
		.rgb         (rgb),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	bdd_rgb_checker #(
		.MAX_LINE_WIDTH(MAX_W)
	) rgb_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample      (sample),
		.rgb_valid   (rgb_valid),
		.rgb_ready   (rgb_ready),
		.rgb         (rgb),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.rgb_checked (rgb_checked)
	);

	function automatic int unsigned clamp_width(input logic [CFG_DATA_W-1:0] val);
		if (val < 2) return 2;
		if (val > MAX_W) return MAX_W;
		return 32'(val);
	endfunction

	task automatic push_sample(input logic [7:0] px, input logic fs);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= '{pixel: px, frame_start: fs};
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		beats_sent++;
	endtask

	task automatic write_reg(input bdd_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_LINE_WIDTH) width_now = val;
		reg_writes++;
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// stress: 1 holds the rgb side off mid-phase, 2 drains mid-phase
	task automatic send_frames(input int unsigned budget, input int unsigned stress);
		int unsigned w, rows, len, sent;
		logic        first;
		sent  = 0;
		first = 1'b1;
		w     = clamp_width(width_now);
		while (sent < budget) begin
			rows = (w > 24) ? $urandom_range(1, 2) : $urandom_range(1, 6);
			len  = rows * w;
			if ($urandom_range(3) == 0) len += $urandom_range(w - 1);
			for (int unsigned i = 0; i < len; i++) begin
				if (sent == budget / 2 && stress == 1) hold_requests++;
				if (sent == budget / 2 && stress == 2) wait_drained();
				push_sample(8'($urandom_range(255)),
					(i == 0) ? (first || $urandom_range(9) != 0) : ($urandom_range(199) == 0));
				sent++;
			end
			first = 1'b0;
		end
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_served != hold_requests) begin
				hold_served++;
				rgb_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				rgb_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		#5000000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int unsigned r;
		arst_n       = 1'b0;
		rgb_ready    = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		cfg_we       = 1'b0;
		cfg_index    = REG_TILE_PATTERN;
		cfg_data     = '0;
		width_now    = LINE_WIDTH_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_TILE_PATTERN, CFG_DATA_W'(TILE_RGGB));
		write_reg(REG_LINE_WIDTH, 12'd0);
		push_sample(8'd255, 1'b1);
		push_sample(8'd255, 1'b0);
		push_sample(8'd255, 1'b0);
		push_sample(8'd0, 1'b0);
		push_sample(8'd0, 1'b0);
		push_sample(8'd254, 1'b0);
		push_sample(8'd255, 1'b0);
		push_sample(8'd255, 1'b0);
		wait_drained();

		write_reg(REG_TILE_PATTERN, CFG_DATA_W'(TILE_GBRG));
		write_reg(REG_LINE_WIDTH, 12'd5);
		for (int unsigned i = 0; i < 15; i++)
			push_sample(8'($urandom_range(255)), i == 0);
		wait_drained();

		for (int unsigned p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 88;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 88;
				end
				default: begin
					send_idle_pct  = 21;
					recv_stall_pct = 21;
				end
			endcase
			write_reg(REG_TILE_PATTERN, CFG_DATA_W'((p + p / 4) % 4));
			r = $urandom_range(9);
			if (p == 0) write_reg(REG_LINE_WIDTH, 12'd8);
			else if (r == 0) write_reg(REG_LINE_WIDTH, CFG_DATA_W'($urandom_range(1)));
			else if (r == 1) write_reg(REG_LINE_WIDTH, CFG_DATA_W'($urandom_range(25, 130)));
			else write_reg(REG_LINE_WIDTH, CFG_DATA_W'($urandom_range(2, 24)));
			send_frames(PHASE_BEATS, (p == 0) ? 1 : ((p == 5) ? 2 : 0));
			wait_drained();
		end

		repeat (8) @(posedge clk);
		$display("Checked %0d rgb beats from %0d sample beats over %0d register writes.",
			rgb_checked, beats_sent, reg_writes);
		$display("Covered all tile orders, low-clamped widths, odd edges, frame restarts, stalls.");
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
